// ----- rtl/wws_pkg.sv -----
// ----------------------------------------------------------------------------
// wws_pkg
// Shared types and constants for the wind window statistics block.
// ----------------------------------------------------------------------------
package wws_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int WLEN_W      = 7;
    localparam int SPEED_W     = 16;
    localparam int MSEL_W      = 3;
    localparam int COUNT_W     = 8;

    // register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_LEN     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WIND_LIMIT     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MEASURE_SELECT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_RETRY_LIMIT    = 3'd3;

    // register reset values
    localparam logic [WLEN_W-1:0]  WLEN_RESET   = 7'd16;
    localparam logic [SPEED_W-1:0] LIMIT_RESET  = 16'hFFFF;
    localparam logic [MSEL_W-1:0]  MSEL_RESET   = 3'd1;
    localparam logic [COUNT_W-1:0] RETRY_RESET  = 8'd3;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = 8'hFF;

    // measure_select codes
    localparam logic [MSEL_W-1:0] MSEL_MAX  = 3'd2;
    localparam logic [MSEL_W-1:0] MSEL_MIN  = 3'd3;
    localparam logic [MSEL_W-1:0] MSEL_MEAN = 3'd4;

    // control from the sequencer to the sample ring
    typedef struct packed {
        logic wr_en;
        logic scan_start;
    } wws_ring_ctl_t;

endpackage

// ----- rtl/wws_ring.sv -----
// ----------------------------------------------------------------------------
// wws_ring
// Sample ring memory with a scanner that reads entries 0..len-1 one per cycle
// and accumulates minimum, maximum and sum.
// ----------------------------------------------------------------------------
module wws_ring
    import wws_pkg::*;
#(
    parameter int WINDOW_DEPTH = 64,
    parameter int SAMPLE_BITS  = 16
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  wws_ring_ctl_t                              ctl,
    input  logic [((WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1)-1:0] wr_addr,
    input  logic [SAMPLE_BITS-1:0]                     wr_data,
    input  logic [$clog2(WINDOW_DEPTH+1)-1:0]          scan_len,
    output logic                                       scan_done,
    output logic [SAMPLE_BITS-1:0]                     scan_min,
    output logic [SAMPLE_BITS-1:0]                     scan_max,
    output logic [SAMPLE_BITS+$clog2(WINDOW_DEPTH+1)-1:0] scan_sum
);

    localparam int ADDR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int LEN_W  = $clog2(WINDOW_DEPTH+1);
    localparam int SUM_W  = SAMPLE_BITS + LEN_W;

    logic [SAMPLE_BITS-1:0] mem [WINDOW_DEPTH];
    logic [SAMPLE_BITS-1:0] rd_data_reg;

    logic             busy_reg;
    logic [LEN_W-1:0] issue_cnt_reg;
    logic             dvld_reg;
    logic             last_reg;
    logic             first_reg;
    logic             done_reg;
    logic             issue_last;

    logic [SAMPLE_BITS-1:0] min_reg;
    logic [SAMPLE_BITS-1:0] max_reg;
    logic [SUM_W-1:0]       sum_reg;

    assign issue_last = (issue_cnt_reg == (scan_len - LEN_W'(1)));

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[issue_cnt_reg[ADDR_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            issue_cnt_reg <= '0;
            dvld_reg      <= 1'b0;
            last_reg      <= 1'b0;
            first_reg     <= 1'b0;
            done_reg      <= 1'b0;
        end else begin
            dvld_reg <= busy_reg;
            last_reg <= busy_reg && issue_last;
            done_reg <= dvld_reg && last_reg;
            if (ctl.scan_start) begin
                busy_reg      <= 1'b1;
                issue_cnt_reg <= '0;
                first_reg     <= 1'b1;
            end else begin
                if (busy_reg) begin
                    issue_cnt_reg <= issue_cnt_reg + LEN_W'(1);
                    if (issue_last) begin
                        busy_reg <= 1'b0;
                    end
                end
                if (dvld_reg) begin
                    first_reg <= 1'b0;
                end
            end
        end
    end

    // accumulate stage, one entry per cycle
    always_ff @(posedge aclk) begin
        if (dvld_reg) begin
            if (first_reg) begin
                min_reg <= rd_data_reg;
                max_reg <= rd_data_reg;
                sum_reg <= SUM_W'(rd_data_reg);
            end else begin
                if (rd_data_reg < min_reg) begin
                    min_reg <= rd_data_reg;
                end
                if (rd_data_reg > max_reg) begin
                    max_reg <= rd_data_reg;
                end
                sum_reg <= sum_reg + SUM_W'(rd_data_reg);
            end
        end
    end

    assign scan_done = done_reg;
    assign scan_min  = min_reg;
    assign scan_max  = max_reg;
    assign scan_sum  = sum_reg;

endmodule

// ----- rtl/wws_div.sv -----
// ----------------------------------------------------------------------------
// wws_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wws_div
    import wws_pkg::*;
#(
    parameter int DIVIDEND_W = 23,
    parameter int DIVISOR_W  = 7
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVIDEND_W-1:0] quo_reg;

    logic [DIVISOR_W:0]    shifted;
    logic                  fits;
    logic [DIVISOR_W:0]    diff;

    always_comb begin
        shifted = {rem_reg, quo_reg[DIVIDEND_W-1]};
        fits    = (shifted >= {1'b0, divisor});
        diff    = shifted - {1'b0, divisor};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(DIVIDEND_W - 1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIVIDEND_W - 1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            // remainder stays below the divisor, so it fits DIVISOR_W bits
            rem_reg <= fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- rtl/wind_window_statistics.sv -----
// ----------------------------------------------------------------------------
// wind_window_statistics
// Anemometer poll selection with a sliding window of min, max and mean.
// ----------------------------------------------------------------------------
// Without a window scan, an accepted item goes to the done state, and the result
// registers and m_valid load from there once the output is free. With a full
// window, the one-entry-per-cycle ring scan and the bit-serial divide come first.
// Throughput: one item at a time; the next item is taken once the result is
// registered, even while it waits on m_ready.
// Reset: synchronous, active low; registers to defaults, window restarted.
// ----------------------------------------------------------------------------
module wind_window_statistics
    import wws_pkg::*;
#(
    parameter int WINDOW_DEPTH = 64,
    parameter int SAMPLE_BITS  = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [15:0]            s_anemometer_a,
    input  logic [15:0]            s_anemometer_b,
    input  logic                   s_read_failed,

    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [15:0]            m_wind_speed,
    output logic                   m_sensor_fault,
    output logic                   m_window_full,
    output logic [15:0]            m_window_min,
    output logic [15:0]            m_window_max,
    output logic [15:0]            m_window_mean,
    output logic [15:0]            m_measure,
    output logic [7:0]             m_error_count,
    output logic                   m_give_up
);

    localparam int ADDR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int LEN_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W  = SAMPLE_BITS + LEN_W;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    function automatic logic [LEN_W-1:0] clamp_len(input logic [WLEN_W-1:0] v);
        logic [LEN_W-1:0] r;
        if (v == '0) begin
            r = LEN_W'(1);
        end else if (32'(v) > WINDOW_DEPTH) begin
            r = LEN_W'(WINDOW_DEPTH);
        end else begin
            r = LEN_W'(v);
        end
        return r;
    endfunction

    state_t state_reg, state_next;

    logic [WLEN_W-1:0]  window_len_reg;
    logic [SPEED_W-1:0] wind_limit_reg;
    logic [MSEL_W-1:0]  measure_select_reg;
    logic [COUNT_W-1:0] retry_limit_reg;

    logic [ADDR_W-1:0]  write_slot_reg;
    logic [LEN_W-1:0]   fill_count_reg;
    logic [SPEED_W-1:0] held_min_reg;
    logic [SPEED_W-1:0] held_max_reg;
    logic [SPEED_W-1:0] held_mean_reg;
    logic [COUNT_W-1:0] fail_count_reg;

    logic [SPEED_W-1:0] speed_reg;
    logic               fault_reg;
    logic               m_valid_reg;

    logic [LEN_W-1:0]   act_len;
    logic               s_accept;
    logic               cfg_accept;
    logic               out_load;
    logic [SPEED_W-1:0] speed_c;
    logic               fault_c;
    logic               store_c;
    logic [LEN_W-1:0]   slot_inc;
    logic [ADDR_W-1:0]  slot_next_c;
    logic [LEN_W-1:0]   fill_inc_c;
    logic               full_after;
    logic [SPEED_W-1:0] measure_c;
    logic [LEN_W-1:0]   cfg_len;

    wws_ring_ctl_t          ring_ctl;
    logic                   scan_done;
    logic [SAMPLE_BITS-1:0] scan_min;
    logic [SAMPLE_BITS-1:0] scan_max;
    logic [SUM_W-1:0]       scan_sum;
    logic                   div_done;
    logic [SUM_W-1:0]       quotient;

    assign act_len    = clamp_len(window_len_reg);
    assign cfg_len    = clamp_len(cfg_data[WLEN_W-1:0]);
    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign s_ready    = (state_reg == ST_IDLE);
    assign s_accept   = s_valid && s_ready;
    assign out_load   = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    always_comb begin
        speed_c = '0;
        fault_c = 1'b0;
        if (!s_read_failed) begin
            if (s_anemometer_a < wind_limit_reg) begin
                speed_c = s_anemometer_a;
            end else if (s_anemometer_b < wind_limit_reg) begin
                speed_c = s_anemometer_b;
            end else begin
                fault_c = 1'b1;
            end
        end
        store_c     = s_accept && !s_read_failed && !fault_c;
        slot_inc    = LEN_W'(write_slot_reg) + LEN_W'(1);
        slot_next_c = (slot_inc >= act_len) ? '0 : slot_inc[ADDR_W-1:0];
        fill_inc_c  = (fill_count_reg < act_len) ? fill_count_reg + LEN_W'(1)
                                                 : fill_count_reg;
        full_after  = (fill_inc_c >= act_len);
        ring_ctl.wr_en      = store_c;
        ring_ctl.scan_start = store_c && full_after;
    end

    always_comb begin
        case (measure_select_reg)
            MSEL_MAX:  measure_c = held_max_reg;
            MSEL_MIN:  measure_c = held_min_reg;
            MSEL_MEAN: measure_c = held_mean_reg;
            default:   measure_c = speed_reg;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ring_ctl.scan_start ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            window_len_reg     <= WLEN_RESET;
            wind_limit_reg     <= LIMIT_RESET;
            measure_select_reg <= MSEL_RESET;
            retry_limit_reg    <= RETRY_RESET;
            write_slot_reg     <= ADDR_W'(clamp_len(WLEN_RESET) - LEN_W'(1));
            fill_count_reg     <= '0;
            held_min_reg       <= '0;
            held_max_reg       <= '0;
            held_mean_reg      <= '0;
            fail_count_reg     <= '0;
            m_valid_reg        <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (s_accept) begin
                if (s_read_failed) begin
                    if (fail_count_reg != COUNT_MAX) begin
                        fail_count_reg <= fail_count_reg + COUNT_W'(1);
                    end
                end else begin
                    fail_count_reg <= '0;
                end
            end

            if (store_c) begin
                write_slot_reg <= slot_next_c;
                fill_count_reg <= fill_inc_c;
            end

            if (scan_done) begin
                held_min_reg <= SPEED_W'(scan_min);
                held_max_reg <= SPEED_W'(scan_max);
            end
            if (div_done) begin
                held_mean_reg <= SPEED_W'(quotient);
            end

            if (cfg_accept) begin
                unique case (cfg_index)
                    CFG_WINDOW_LEN: begin
                        // new length restarts the window
                        window_len_reg <= cfg_data[WLEN_W-1:0];
                        write_slot_reg <= ADDR_W'(cfg_len - LEN_W'(1));
                        fill_count_reg <= '0;
                        held_min_reg   <= '0;
                        held_max_reg   <= '0;
                        held_mean_reg  <= '0;
                    end
                    CFG_WIND_LIMIT:     wind_limit_reg     <= cfg_data[SPEED_W-1:0];
                    CFG_MEASURE_SELECT: measure_select_reg <= cfg_data[MSEL_W-1:0];
                    CFG_RETRY_LIMIT:    retry_limit_reg    <= cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            speed_reg <= speed_c;
            fault_reg <= fault_c;
        end
        if (out_load) begin
            m_wind_speed   <= speed_reg;
            m_sensor_fault <= fault_reg;
            m_window_full  <= (fill_count_reg >= act_len);
            m_window_min   <= held_min_reg;
            m_window_max   <= held_max_reg;
            m_window_mean  <= held_mean_reg;
            m_measure      <= measure_c;
            m_error_count  <= fail_count_reg;
            m_give_up      <= fault_reg || (fail_count_reg >= retry_limit_reg);
        end
    end

    assign m_valid = m_valid_reg;

    wws_ring #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_ring (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ring_ctl),
        .wr_addr   (slot_next_c),
        .wr_data   (SAMPLE_BITS'(speed_c)),
        .scan_len  (act_len),
        .scan_done (scan_done),
        .scan_min  (scan_min),
        .scan_max  (scan_max),
        .scan_sum  (scan_sum)
    );

    wws_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (LEN_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (scan_done),
        .dividend (scan_sum),
        .divisor  (act_len),
        .done     (div_done),
        .quotient (quotient)
    );

    // scan and divide results only arrive in their own states
    a_scan_in_state: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_done |-> (state_reg == ST_SCAN))
        else $error("scan finished outside of scan state");

    a_div_in_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV))
        else $error("divide finished outside of divide state");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_count_reg <= act_len)
        else $error("fill count beyond window length");

    // statistics stay zero until full, and with 16-bit samples the mean lies between min and max
    a_stats_sane: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_window_full
            ? ((SAMPLE_BITS > 16) || ((m_window_min <= m_window_mean)
                                   && (m_window_mean <= m_window_max)))
            : ((m_window_min == '0) && (m_window_max == '0)
                                    && (m_window_mean == '0))))
        else $error("window statistics inconsistent");

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for wind_window_statistics.
// Directed polls, window length sweeps, failure count saturation and random
// register phases. Every result is compared against an in-bench model of the
// poll selection, the sample ring and the window statistics, with random
// gaps on the poll side and random back-pressure on the result side.
// ----------------------------------------------------------------------------
module tb;
    import wws_pkg::*;

    localparam int RING_DEPTH = 64;

    typedef struct {
        logic [15:0] wind_speed;
        logic        sensor_fault;
        logic        window_full;
        logic [15:0] window_min;
        logic [15:0] window_max;
        logic [15:0] window_mean;
        logic [15:0] measure;
        logic [7:0]  error_count;
        logic        give_up;
    } poll_stats_t;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_valid;
    logic                   s_ready;
    logic [15:0]            s_anemometer_a;
    logic [15:0]            s_anemometer_b;
    logic                   s_read_failed;
    logic                   m_valid;
    logic                   m_ready;
    logic [15:0]            m_wind_speed;
    logic                   m_sensor_fault;
    logic                   m_window_full;
    logic [15:0]            m_window_min;
    logic [15:0]            m_window_max;
    logic [15:0]            m_window_mean;
    logic [15:0]            m_measure;
    logic [7:0]             m_error_count;
    logic                   m_give_up;

    // model registers and state
    logic [WLEN_W-1:0]  cur_len;
    logic [SPEED_W-1:0] cur_limit;
    logic [MSEL_W-1:0]  cur_msel;
    logic [COUNT_W-1:0] cur_retry;
    logic [15:0]        wind_ring [RING_DEPTH];
    int unsigned        ring_slot;
    int unsigned        ring_fill;
    logic [15:0]        stat_min;
    logic [15:0]        stat_max;
    logic [15:0]        stat_mean;
    logic [7:0]         fail_run;

    poll_stats_t pending_stats[$];
    int          polls_sent;
    int          stats_checked;
    int          faults_seen;
    int          full_seen;
    int          mismatches;
    logic        steady_tail;

    wind_window_statistics #(
        .WINDOW_DEPTH(RING_DEPTH),
        .SAMPLE_BITS (16)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_anemometer_a(s_anemometer_a),
        .s_anemometer_b(s_anemometer_b),
        .s_read_failed (s_read_failed),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_wind_speed  (m_wind_speed),
        .m_sensor_fault(m_sensor_fault),
        .m_window_full (m_window_full),
        .m_window_min  (m_window_min),
        .m_window_max  (m_window_max),
        .m_window_mean (m_window_mean),
        .m_measure     (m_measure),
        .m_error_count (m_error_count),
        .m_give_up     (m_give_up)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // model
    // ------------------------------------------------------------------
    function automatic int unsigned window_span();
        if (cur_len == 0) return 1;
        if (cur_len > RING_DEPTH) return RING_DEPTH;
        return cur_len;
    endfunction

    function automatic void restart_window();
        ring_slot = window_span() - 1;
        ring_fill = 0;
        stat_min  = '0;
        stat_max  = '0;
        stat_mean = '0;
    endfunction

    function automatic void reset_model();
        cur_len   = WLEN_RESET;
        cur_limit = LIMIT_RESET;
        cur_msel  = MSEL_RESET;
        cur_retry = RETRY_RESET;
        fail_run  = '0;
        restart_window();
    endfunction

    function automatic void apply_reg(logic [CFG_INDEX_W-1:0] index,
                                      logic [CFG_DATA_W-1:0] data);
        case (index)
            CFG_WINDOW_LEN: begin
                cur_len = data[WLEN_W-1:0];
                restart_window();
            end
            CFG_WIND_LIMIT:     cur_limit = data[SPEED_W-1:0];
            CFG_MEASURE_SELECT: cur_msel  = data[MSEL_W-1:0];
            CFG_RETRY_LIMIT:    cur_retry = data[COUNT_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic poll_stats_t predict_poll(logic [15:0] a, logic [15:0] b,
                                                 logic failed);
        poll_stats_t r;
        logic [15:0] speed;
        logic        fault;
        int unsigned span;
        int unsigned sum;
        logic [15:0] lo;
        logic [15:0] hi;
        speed = '0;
        fault = 1'b0;
        span  = window_span();
        if (failed) begin
            if (fail_run != COUNT_MAX) fail_run = fail_run + 1'b1;
        end else begin
            fail_run = '0;
            if (a < cur_limit) speed = a;
            else if (b < cur_limit) speed = b;
            else fault = 1'b1;
            if (!fault) begin
                ring_slot = (ring_slot + 1 >= span) ? 0 : ring_slot + 1;
                wind_ring[ring_slot] = speed;
                if (ring_fill < span) ring_fill++;
                // rescan the whole ring on every good sample once it is full
                if (ring_fill >= span) begin
                    lo  = wind_ring[0];
                    hi  = wind_ring[0];
                    sum = 0;
                    for (int i = 0; i < span; i++) begin
                        if (wind_ring[i] < lo) lo = wind_ring[i];
                        if (wind_ring[i] > hi) hi = wind_ring[i];
                        sum += wind_ring[i];
                    end
                    stat_min  = lo;
                    stat_max  = hi;
                    stat_mean = 16'(sum / span);
                end
            end
        end
        case (cur_msel)
            MSEL_MAX:  r.measure = stat_max;
            MSEL_MIN:  r.measure = stat_min;
            MSEL_MEAN: r.measure = stat_mean;
            default:   r.measure = speed;
        endcase
        r.wind_speed   = speed;
        r.sensor_fault = fault;
        r.window_full  = (ring_fill >= span);
        r.window_min   = stat_min;
        r.window_max   = stat_max;
        r.window_mean  = stat_mean;
        r.error_count  = fail_run;
        r.give_up      = fault || (fail_run >= cur_retry);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t, result %0d: %s", $realtime, stats_checked, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    always @(posedge aclk) begin : result_check
        poll_stats_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_stats.size() == 0) begin
                report_mismatch("result item with nothing expected");
            end else begin
                want = pending_stats.pop_front();
                check_field("wind_speed",   m_wind_speed,   want.wind_speed);
                check_field("sensor_fault", m_sensor_fault, want.sensor_fault);
                check_field("window_full",  m_window_full,  want.window_full);
                check_field("window_min",   m_window_min,   want.window_min);
                check_field("window_max",   m_window_max,   want.window_max);
                check_field("window_mean",  m_window_mean,  want.window_mean);
                check_field("measure",      m_measure,      want.measure);
                check_field("error_count",  m_error_count,  want.error_count);
                check_field("give_up",      m_give_up,      want.give_up);
                if (want.sensor_fault) faults_seen++;
                if (want.window_full) full_seen++;
                stats_checked++;
            end
        end
    end

    // result side back-pressure in bursts
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (steady_tail) begin
                m_ready <= 1'b1;
            end else if ($urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 15) - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(0, 30)) @(negedge aclk);
            end
        end
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    task automatic send_poll(input logic [15:0] a, input logic [15:0] b,
                             input logic failed);
        int gap;
        if (!steady_tail && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid        <= 1'b1;
        s_anemometer_a <= a;
        s_anemometer_b <= b;
        s_read_failed  <= failed;
        do @(posedge aclk); while (!s_ready);
        pending_stats.push_back(predict_poll(a, b, failed));
        polls_sent++;
    endtask

    // wait until every result is back, the block is idle afterwards
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_stats.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        apply_reg(index, data);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] reading_below();
        if (cur_limit == 0) return 16'($urandom);
        case ($urandom_range(0, 3))
            0:       return 16'h0000;
            1:       return cur_limit - 1'b1;
            default: return 16'($urandom_range(0, cur_limit - 1));
        endcase
    endfunction

    function automatic logic [15:0] reading_faulty();
        case ($urandom_range(0, 3))
            0:       return cur_limit;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(cur_limit, 65535));
        endcase
    endfunction

    task automatic send_random_poll();
        int kind;
        kind = $urandom_range(0, 19);
        if (kind < 3) send_poll(16'($urandom), 16'($urandom), 1'b1);
        else if (kind < 5) send_poll(reading_faulty(), reading_faulty(), 1'b0);
        else if (kind < 8) send_poll(reading_faulty(), reading_below(), 1'b0);
        else send_poll(reading_below(), 16'($urandom), 1'b0);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        int sel;
        // failed polls build up the error count, give-up at the default limit
        repeat (4) send_poll(16'hFFFF, 16'h0000, 1'b1);
        send_poll(16'h0000, 16'hFFFF, 1'b0);
        // both readings at the limit, backup only, primary just below
        send_poll(16'hFFFF, 16'hFFFF, 1'b0);
        send_poll(16'hFFFF, 16'h0001, 1'b0);
        send_poll(16'hFFFE, 16'hFFFF, 1'b0);
        drain();
        write_reg(CFG_WINDOW_LEN, 16'd1);
        for (sel = 0; sel < 8; sel++) begin
            drain();
            write_reg(CFG_MEASURE_SELECT, 16'(sel));
            send_poll(16'($urandom), 16'h5555, 1'b0);
        end
        // zero limit faults every successful poll
        drain();
        write_reg(CFG_WIND_LIMIT, 16'h0000);
        send_poll(16'h0000, 16'h0000, 1'b0);
        send_poll(16'hAAAA, 16'h5555, 1'b1);
        drain();
        write_reg(CFG_WIND_LIMIT, 16'hFFFF);
        write_reg(CFG_RETRY_LIMIT, 16'd0);
        send_poll(16'h8000, 16'h0000, 1'b0);
        // zero window length acts as one
        drain();
        write_reg(CFG_WINDOW_LEN, 16'd0);
        send_poll(16'h7FFF, 16'h0000, 1'b0);
        send_poll(16'h0001, 16'h0000, 1'b0);
    endtask

    task automatic test_window_sizes();
        int lens [8];
        int n;
        lens = '{1, 2, 3, 0, 64, 65, 127, 5};
        drain();
        write_reg(CFG_RETRY_LIMIT, 16'd3);
        for (int i = 0; i < 8; i++) begin
            drain();
            write_reg(CFG_WINDOW_LEN, 16'(lens[i]));
            write_reg(CFG_WIND_LIMIT,
                      (i % 2) ? 16'hFFFF : 16'($urandom_range(1000, 65535)));
            write_reg(CFG_MEASURE_SELECT, 16'(i));
            n = window_span() + 6;
            repeat (n) send_random_poll();
        end
    endtask

    task automatic test_fail_saturation();
        drain();
        write_reg(CFG_RETRY_LIMIT, 16'd255);
        write_reg(CFG_MEASURE_SELECT, 16'd1);
        repeat (258) send_poll(16'($urandom), 16'($urandom), 1'b1);
        send_poll(16'h1234, 16'h0000, 1'b0);
        drain();
        write_reg(CFG_RETRY_LIMIT, 16'd1);
        send_poll(16'h0000, 16'h0000, 1'b1);
        send_poll(16'h0000, 16'h0000, 1'b1);
        send_poll(16'h4321, 16'h0000, 1'b0);
    endtask

    task automatic test_random();
        int first;
        int phase_len;
        first = polls_sent;
        while (polls_sent - first < 1200) begin
            drain();
            // no idling on either side for the last stretch
            if (polls_sent - first >= 1050) steady_tail = 1'b1;
            if ($urandom_range(0, 1)) begin
                case ($urandom_range(0, 9))
                    0:       write_reg(CFG_WINDOW_LEN, 16'd64);
                    1:       write_reg(CFG_WINDOW_LEN, 16'($urandom_range(65, 127)));
                    2:       write_reg(CFG_WINDOW_LEN, 16'd0);
                    default: write_reg(CFG_WINDOW_LEN, 16'($urandom_range(1, 8)));
                endcase
            end
            if ($urandom_range(0, 1)) begin
                case ($urandom_range(0, 5))
                    0:       write_reg(CFG_WIND_LIMIT, 16'h0000);
                    1:       write_reg(CFG_WIND_LIMIT, 16'hFFFF);
                    2:       write_reg(CFG_WIND_LIMIT, 16'($urandom));
                    3:       write_reg(CFG_WIND_LIMIT, 16'($urandom_range(1, 255)));
                    default: write_reg(CFG_WIND_LIMIT, 16'($urandom_range(32768, 65535)));
                endcase
            end
            if ($urandom_range(0, 1))
                write_reg(CFG_MEASURE_SELECT, 16'($urandom_range(0, 7)));
            if ($urandom_range(0, 1)) begin
                case ($urandom_range(0, 5))
                    0:       write_reg(CFG_RETRY_LIMIT, 16'd0);
                    1:       write_reg(CFG_RETRY_LIMIT, 16'd255);
                    default: write_reg(CFG_RETRY_LIMIT, 16'($urandom_range(1, 6)));
                endcase
            end
            phase_len = $urandom_range(10, 60);
            repeat (phase_len) send_random_poll();
        end
    endtask

    initial begin
        aresetn        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        s_valid        = 1'b0;
        s_anemometer_a = '0;
        s_anemometer_b = '0;
        s_read_failed  = 1'b0;
        steady_tail    = 1'b0;
        polls_sent     = 0;
        stats_checked  = 0;
        faults_seen    = 0;
        full_seen      = 0;
        mismatches     = 0;
        reset_model();
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_window_sizes();
        test_fail_saturation();
        test_random();
        drain();
        // allow a full-window scan to finish in case a stray item shows up
        repeat (150) @(posedge aclk);

        $display("run covered %0d polls and %0d checked results", polls_sent,
                 stats_checked);
        $display("%0d sensor faults, %0d results with a full window, %0d mismatches",
                 faults_seen, full_seen, mismatches);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("timeout with %0d results outstanding", pending_stats.size());
        $display("status: fail");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/wws_pkg.sv
rtl/wws_ring.sv
rtl/wws_div.sv
rtl/wind_window_statistics.sv
sim/tb.sv
